[hw/rtl/dpalu_pkg.sv]
// Shared types and constants for the data-processing ALU with shifter.
// Holds opcode and shift-kind codes, stage payload structs and stream widths.
// No dependencies.
package dpalu_pkg;

    localparam int unsigned WORD_W   = 32;
    localparam int unsigned IN_TDATA_W  = 112;
    localparam int unsigned OUT_TDATA_W = 48;
    localparam logic [3:0]  PC_INDEX = 4'd15;

    localparam logic [3:0] OP_AND = 4'd0;
    localparam logic [3:0] OP_EOR = 4'd1;
    localparam logic [3:0] OP_SUB = 4'd2;
    localparam logic [3:0] OP_RSB = 4'd3;
    localparam logic [3:0] OP_ADD = 4'd4;
    localparam logic [3:0] OP_ADC = 4'd5;
    localparam logic [3:0] OP_SBC = 4'd6;
    localparam logic [3:0] OP_RSC = 4'd7;
    localparam logic [3:0] OP_TST = 4'd8;
    localparam logic [3:0] OP_TEQ = 4'd9;
    localparam logic [3:0] OP_CMP = 4'd10;
    localparam logic [3:0] OP_CMN = 4'd11;
    localparam logic [3:0] OP_ORR = 4'd12;
    localparam logic [3:0] OP_MOV = 4'd13;
    localparam logic [3:0] OP_BIC = 4'd14;
    localparam logic [3:0] OP_MVN = 4'd15;

    localparam logic [1:0] SH_LSL = 2'd0;
    localparam logic [1:0] SH_LSR = 2'd1;
    localparam logic [1:0] SH_ASR = 2'd2;
    localparam logic [1:0] SH_ROR = 2'd3;

    localparam logic [7:0] FULL_SHIFT = 8'd32;

    typedef struct packed {
        logic [3:0]        op;
        logic [3:0]        rd;
        logic              sbit;
        logic [WORD_W-1:0] rn;
        logic [WORD_W-1:0] so;
        logic              sc;
        logic [3:0]        fin;
        logic              spsr;
    } t_sh_req;

    typedef struct packed {
        logic [3:0]        op;
        logic [3:0]        rd;
        logic              sbit;
        logic [WORD_W-1:0] res;
        logic              c;
        logic              v;
        logic [3:0]        fin;
        logic              spsr;
    } t_alu_res;

    function automatic logic [WORD_W-1:0] ror32(input logic [WORD_W-1:0] v,
                                                input logic [4:0] n);
        logic [2*WORD_W-1:0] w;
        w = {v, v} >> n;
        return w[WORD_W-1:0];
    endfunction

endpackage

[hw/rtl/data_processing_alu_with_shifter_core.sv]
// Top level of the data-processing ALU with barrel shifter.
// Instantiates dpalu_shift, dpalu_exec and dpalu_wb; depends on dpalu_pkg.
//
// Executes one 32-bit data-processing instruction per request: shifter operand
// (rotated immediate, or Rm shifted by LSL/LSR/ASR/ROR/RRX by an immediate or Rs
// amount), sixteen ALU opcodes, new NZCV flags, register write and SPSR restore
// indication. Throughput is one request per clock cycle while the output is not
// stalled, using one register stage each for the shifter, the 33-bit adder and
// the flag/output logic. Each stage holds its contents while the next one is full,
// so bubbles are squeezed out and the input accepts while any stage has room.
module data_processing_alu_with_shifter_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // instruction[31:0], first_operand[63:32], shifted_register[95:64],
    // shift_register_byte[103:96], flags_in[107:104], has_saved_status[108]
    input  logic [dpalu_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // result_value[31:0], dest_index[35:32], write_dest[36], flags_out[40:37],
    // write_flags[41], restore_status[42]
    output logic [dpalu_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import dpalu_pkg::*;

    logic     sh_valid;
    logic     sh_ready;
    t_sh_req  sh_req;
    logic     ex_valid;
    logic     ex_ready;
    t_alu_res ex_res;
    logic     tdata_pad;

    assign tdata_pad = |s_axis_tdata[IN_TDATA_W-1:109];

    dpalu_shift u_shift (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_valid               (s_axis_tvalid),
        .o_ready               (s_axis_tready),
        .i_instruction         (s_axis_tdata[31:0]),
        .i_first_operand       (s_axis_tdata[63:32]),
        .i_shifted_register    (s_axis_tdata[95:64]),
        .i_shift_register_byte (s_axis_tdata[103:96]),
        .i_flags_in            (s_axis_tdata[107:104]),
        .i_has_saved_status    (s_axis_tdata[108] | (tdata_pad & 1'b0)),
        .o_valid               (sh_valid),
        .i_ready               (sh_ready),
        .o_req                 (sh_req)
    );

    dpalu_exec u_exec (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (sh_valid),
        .o_ready (sh_ready),
        .i_req   (sh_req),
        .o_valid (ex_valid),
        .i_ready (ex_ready),
        .o_res   (ex_res)
    );

    dpalu_wb u_wb (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (ex_valid),
        .o_ready (ex_ready),
        .i_res   (ex_res),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (m_axis_tdata)
    );

endmodule

[hw/rtl/dpalu_shift.sv]
// First stage: instruction field decode and barrel shifter with carry out.
// Depends on dpalu_pkg.
module dpalu_shift (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [31:0]         i_instruction,
    input  logic [31:0]         i_first_operand,
    input  logic [31:0]         i_shifted_register,
    input  logic [7:0]          i_shift_register_byte,
    input  logic [3:0]          i_flags_in,
    input  logic                i_has_saved_status,
    output logic                o_valid,
    input  logic                i_ready,
    output dpalu_pkg::t_sh_req  o_req
);
    import dpalu_pkg::*;

    logic          r_valid;
    t_sh_req       r_req;
    t_sh_req       n_req;
    logic [1:0]    kind;
    logic          reg_mode;
    logic          cin;
    logic [4:0]    rot;
    logic [31:0]   imm_val;
    logic [7:0]    amt;
    logic [7:0]    amt_e;
    logic [32:0]   lsl_w;
    logic [32:0]   lsr_w;
    logic [32:0]   asr_w;
    logic [31:0]   ror_v;
    logic [31:0]   so;
    logic          sc;

    assign kind     = i_instruction[6:5];
    assign reg_mode = i_instruction[4];
    assign cin      = i_flags_in[1];
    assign rot      = {i_instruction[11:8], 1'b0};
    assign imm_val  = ror32({24'd0, i_instruction[7:0]}, rot);
    assign amt      = reg_mode ? i_shift_register_byte : {3'd0, i_instruction[11:7]};

    always_comb begin
        amt_e = amt;
        if (!reg_mode && amt == 8'd0 && (kind == SH_LSR || kind == SH_ASR)) begin
            amt_e = FULL_SHIFT;
        end
    end

    assign lsl_w = {1'b0, i_shifted_register} << amt_e;
    assign lsr_w = {i_shifted_register, 1'b0} >> amt_e;
    assign asr_w = $unsigned($signed({i_shifted_register, 1'b0}) >>> amt_e);
    assign ror_v = ror32(i_shifted_register, amt_e[4:0]);

    always_comb begin
        so = i_shifted_register;
        sc = cin;
        if (i_instruction[25]) begin
            so = imm_val;
            sc = (rot == 5'd0) ? cin : imm_val[31];
        end else if (!reg_mode && amt == 8'd0 && kind == SH_ROR) begin
            so = {cin, i_shifted_register[31:1]};
            sc = i_shifted_register[0];
        end else if (amt_e != 8'd0) begin
            case (kind)
                SH_LSL: begin
                    so = lsl_w[31:0];
                    sc = lsl_w[32];
                end
                SH_LSR: begin
                    so = lsr_w[32:1];
                    sc = lsr_w[0];
                end
                SH_ASR: begin
                    so = asr_w[32:1];
                    sc = asr_w[0];
                end
                default: begin
                    so = ror_v;
                    sc = ror_v[31];
                end
            endcase
        end
    end

    always_comb begin
        n_req.op   = i_instruction[24:21];
        n_req.rd   = i_instruction[15:12];
        n_req.sbit = i_instruction[20];
        n_req.rn   = i_first_operand;
        n_req.so   = so;
        n_req.sc   = sc;
        n_req.fin  = i_flags_in;
        n_req.spsr = i_has_saved_status;
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_req <= n_req;
        end
    end

    assign o_valid = r_valid;
    assign o_req   = r_req;

endmodule

[hw/rtl/dpalu_exec.sv]
// Second stage: logical operations and the carry-inclusive 33-bit adder.
// Depends on dpalu_pkg.
module dpalu_exec (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  dpalu_pkg::t_sh_req  i_req,
    output logic                o_valid,
    input  logic                i_ready,
    output dpalu_pkg::t_alu_res o_res
);
    import dpalu_pkg::*;

    logic        r_valid;
    t_alu_res    r_res;
    t_alu_res    n_res;
    logic [31:0] a;
    logic [31:0] b;
    logic        ci;
    logic        arith;
    logic [32:0] sum;
    logic [31:0] logic_res;
    logic        cin;

    assign cin = i_req.fin[1];

    always_comb begin
        a         = i_req.rn;
        b         = i_req.so;
        ci        = 1'b0;
        arith     = 1'b1;
        logic_res = i_req.rn & i_req.so;
        case (i_req.op)
            OP_AND, OP_TST: begin
                arith     = 1'b0;
            end
            OP_EOR, OP_TEQ: begin
                arith     = 1'b0;
                logic_res = i_req.rn ^ i_req.so;
            end
            OP_SUB, OP_CMP: begin
                b  = ~i_req.so;
                ci = 1'b1;
            end
            OP_RSB: begin
                a  = i_req.so;
                b  = ~i_req.rn;
                ci = 1'b1;
            end
            OP_ADD, OP_CMN: begin
                ci = 1'b0;
            end
            OP_ADC: begin
                ci = cin;
            end
            OP_SBC: begin
                b  = ~i_req.so;
                ci = cin;
            end
            OP_RSC: begin
                a  = i_req.so;
                b  = ~i_req.rn;
                ci = cin;
            end
            OP_ORR: begin
                arith     = 1'b0;
                logic_res = i_req.rn | i_req.so;
            end
            OP_MOV: begin
                arith     = 1'b0;
                logic_res = i_req.so;
            end
            OP_BIC: begin
                arith     = 1'b0;
                logic_res = i_req.rn & ~i_req.so;
            end
            default: begin
                arith     = 1'b0;
                logic_res = ~i_req.so;
            end
        endcase
    end

    assign sum = {1'b0, a} + {1'b0, b} + {32'd0, ci};

    always_comb begin
        n_res.op   = i_req.op;
        n_res.rd   = i_req.rd;
        n_res.sbit = i_req.sbit;
        n_res.fin  = i_req.fin;
        n_res.spsr = i_req.spsr;
        if (arith) begin
            n_res.res = sum[31:0];
            n_res.c   = sum[32];
            n_res.v   = ~(a[31] ^ b[31]) & (a[31] ^ sum[31]);
        end else begin
            n_res.res = logic_res;
            n_res.c   = i_req.sc;
            n_res.v   = i_req.fin[0];
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_res <= n_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

[hw/rtl/dpalu_wb.sv]
// Third stage: flag generation, write enables and the output register.
// Depends on dpalu_pkg.
module dpalu_wb (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  dpalu_pkg::t_alu_res  i_res,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [47:0]          o_data
);
    import dpalu_pkg::*;

    logic        r_valid;
    logic [47:0] r_data;
    logic [47:0] n_data;
    logic        cmp_op;
    logic        pc_s;
    logic        wf;
    logic        rest;
    logic [3:0]  fout;

    always_comb begin
        case (i_res.op)
            OP_TST, OP_TEQ, OP_CMP, OP_CMN: cmp_op = 1'b1;
            default:                        cmp_op = 1'b0;
        endcase
    end

    assign pc_s = i_res.sbit && (i_res.rd == PC_INDEX);
    assign wf   = cmp_op || (i_res.sbit && !pc_s);
    assign rest = !cmp_op && pc_s && i_res.spsr;
    assign fout = wf ? {i_res.res[31], (i_res.res == 32'd0), i_res.c, i_res.v} : i_res.fin;

    assign n_data = {5'd0, rest, wf, fout, !cmp_op, i_res.rd, i_res.res};

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule
